@@ hw/rtl/acenc_pkg.sv @@
// Shared constants, codes and types for the bitwise arithmetic encoder.
package acenc_pkg;

  // Defaults for the top-level parameters
  localparam int CODE_BITS_DEF  = 32;
  localparam int COUNT_BITS_DEF = 16;

  // Fixed field widths of the stream channels
  localparam int CNT_W       = 16;
  localparam int FOLLOW_W    = 32;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 40;
  localparam int MAX_RESULTS = 32;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  localparam logic [FOLLOW_W-1:0] PEND_MAX = '1;

  typedef enum logic [0:0] {
    OP_ENCODE = 1'b0,
    OP_FLUSH  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_RENORM,
    S_DONE,
    S_FLUSH
  } state_t;

endpackage

@@ hw/rtl/acenc_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
module acenc_div #(
  parameter int DIVIDEND_W = 32,
  parameter int DIVISOR_W  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_BITS = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] q_r, q_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  dsr_r, dsr_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                  done_r, done_nxt;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  assign trial    = {rem_r, q_r[DIVIDEND_W-1]};
  assign fits     = trial >= {1'b0, dsr_r};
  assign done     = done_r;
  assign quotient = q_r;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt   = dividend;
      rem_nxt = '0;
      dsr_nxt = divisor;
      cnt_nxt = CNT_BITS'(DIVIDEND_W);
    end else if (cnt_r != '0) begin
      // shift in the next dividend bit, subtract when the divisor fits
      rem_nxt  = fits ? DIVISOR_W'(trial - {1'b0, dsr_r}) : trial[DIVISOR_W-1:0];
      q_nxt    = {q_r[DIVIDEND_W-2:0], fits};
      cnt_nxt  = cnt_r - CNT_BITS'(1);
      done_nxt = (cnt_r == CNT_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> (rem_r < dsr_r))
    else $error("divider remainder not below divisor");

  a_done_after_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (cnt_r == '0))
    else $error("divider done while still iterating");

endmodule

@@ hw/rtl/acenc_mul.sv @@
// Bit-serial dual multiplier: one multiplier bit of both counts per cycle, MSB first.
module acenc_mul #(
  parameter int MCAND_W  = 32,
  parameter int MPLIER_W = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [MCAND_W-1:0]  mcand,
  input  logic [MPLIER_W-1:0] mplier_a,
  input  logic [MPLIER_W-1:0] mplier_b,
  output logic                done,
  output logic [MCAND_W-1:0]  prod_a,
  output logic [MCAND_W-1:0]  prod_b
);

  localparam int CNT_BITS = $clog2(MPLIER_W + 1);

  logic [MCAND_W-1:0]  mc_r, mc_nxt;
  logic [MPLIER_W-1:0] sa_r, sa_nxt;
  logic [MPLIER_W-1:0] sb_r, sb_nxt;
  logic [MCAND_W-1:0]  acc_a_r, acc_a_nxt;
  logic [MCAND_W-1:0]  acc_b_r, acc_b_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                done_r, done_nxt;

  assign done   = done_r;
  assign prod_a = acc_a_r;
  assign prod_b = acc_b_r;

  always_comb begin
    mc_nxt    = mc_r;
    sa_nxt    = sa_r;
    sb_nxt    = sb_r;
    acc_a_nxt = acc_a_r;
    acc_b_nxt = acc_b_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    if (start) begin
      mc_nxt    = mcand;
      sa_nxt    = mplier_a;
      sb_nxt    = mplier_b;
      acc_a_nxt = '0;
      acc_b_nxt = '0;
      cnt_nxt   = CNT_BITS'(MPLIER_W);
    end else if (cnt_r != '0) begin
      // products never exceed the interval width, so the accumulators cannot wrap
      acc_a_nxt = {acc_a_r[MCAND_W-2:0], 1'b0} + (sa_r[MPLIER_W-1] ? mc_r : '0);
      acc_b_nxt = {acc_b_r[MCAND_W-2:0], 1'b0} + (sb_r[MPLIER_W-1] ? mc_r : '0);
      sa_nxt    = {sa_r[MPLIER_W-2:0], 1'b0};
      sb_nxt    = {sb_r[MPLIER_W-2:0], 1'b0};
      cnt_nxt   = cnt_r - CNT_BITS'(1);
      done_nxt  = (cnt_r == CNT_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    mc_r    <= mc_nxt;
    sa_r    <= sa_nxt;
    sb_r    <= sb_nxt;
    acc_a_r <= acc_a_nxt;
    acc_b_r <= acc_b_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  a_mul_done_after_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (cnt_r == '0))
    else $error("multiplier done while still iterating");

endmodule

@@ hw/rtl/arithmetic_encoder_bitwise.sv @@
// Sequence: an encode item runs a serial divide, a serial multiply and then its
//   renormalization shifts until its last group is in the output register; an item
//   that leaves no room for scale is dropped after the divide.
// One item at a time; the next item is taken once the last group is in
//   the output register. A flush or an invalid item does not use the divider.
// Reset: synchronous, active low; clears the interval to [0, all ones], the pending
//   count to zero, and the output register to empty.
module arithmetic_encoder_bitwise #(
  parameter int CODE_BITS  = acenc_pkg::CODE_BITS_DEF,
  parameter int COUNT_BITS = acenc_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [15:0] sym_low, [31:16] sym_high, [47:32] scale
  input  logic [acenc_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] operation
  input  logic [0:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] lead_bit, [32:1] follow_count, [39:33] zero
  output logic [acenc_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                             out_tlast
);

  localparam int VB  = CODE_BITS - 1;
  localparam int CW  = acenc_pkg::CNT_W;
  localparam int FW  = acenc_pkg::FOLLOW_W;
  localparam int RW  = acenc_pkg::RES_CNT_W;
  localparam logic [VB-1:0] NEXT_MASK = VB'(1) << (VB - 2);

  acenc_pkg::state_t state_r, state_nxt;

  logic [VB-1:0] lo_r, lo_nxt;
  logic [VB-1:0] hi_r, hi_nxt;
  logic [FW-1:0] pend_r, pend_nxt;
  logic [RW-1:0] n_r, n_nxt;
  logic [CW-1:0] lc_r, lc_nxt;
  logic [CW-1:0] hc_r, hc_nxt;

  logic          hold_v_r, hold_v_nxt;
  logic          hold_bit_r, hold_bit_nxt;
  logic [FW-1:0] hold_follow_r, hold_follow_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_lead_r, out_lead_nxt;
  logic [FW-1:0] out_follow_r, out_follow_nxt;
  logic          out_last_r, out_last_nxt;

  logic [CW-1:0]        in_lc, in_hc, in_sc;
  logic                 item_ok;
  logic                 oversize;
  logic [CODE_BITS-1:0] width;
  logic                 div_start, div_done;
  logic [CODE_BITS-1:0] quot;
  logic                 mul_start, mul_done;
  logic [CODE_BITS-1:0] prod_h, prod_l;
  logic [CODE_BITS-1:0] sum_h, sum_l;
  logic                 out_free;
  logic                 top_eq, straddle;
  logic [VB-1:0]        lo_tog, hi_tog;

  assign in_lc = in_tdata[CW-1:0];
  assign in_hc = in_tdata[2*CW-1:CW];
  assign in_sc = in_tdata[3*CW-1:2*CW];

  assign oversize = (COUNT_BITS < CW) && ((in_sc >> COUNT_BITS) != '0);
  assign item_ok  = (in_sc != '0) && !oversize && (in_hc <= in_sc) && (in_lc < in_hc);
  assign width    = {1'b0, VB'(hi_r - lo_r)} + CODE_BITS'(1);

  assign sum_h = {1'b0, lo_r} + prod_h - CODE_BITS'(1);
  assign sum_l = {1'b0, lo_r} + prod_l;

  assign top_eq   = (hi_r[VB-1] == lo_r[VB-1]);
  assign straddle = lo_r[VB-2] & ~hi_r[VB-2];
  assign lo_tog   = lo_r ^ NEXT_MASK;
  assign hi_tog   = hi_r ^ NEXT_MASK;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {(acenc_pkg::OUT_DATA_W - FW - 1)'(0), out_follow_r, out_lead_r};

  acenc_div #(
    .DIVIDEND_W (CODE_BITS),
    .DIVISOR_W  (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (width),
    .divisor  (in_sc),
    .done     (div_done),
    .quotient (quot)
  );

  acenc_mul #(
    .MCAND_W  (CODE_BITS),
    .MPLIER_W (CW)
  ) u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mul_start),
    .mcand    (quot),
    .mplier_a (hc_r),
    .mplier_b (lc_r),
    .done     (mul_done),
    .prod_a   (prod_h),
    .prod_b   (prod_l)
  );

  always_comb begin
    state_nxt       = state_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    pend_nxt        = pend_r;
    n_nxt           = n_r;
    lc_nxt          = lc_r;
    hc_nxt          = hc_r;
    hold_v_nxt      = hold_v_r;
    hold_bit_nxt    = hold_bit_r;
    hold_follow_nxt = hold_follow_r;
    out_valid_nxt   = out_valid_r;
    out_lead_nxt    = out_lead_r;
    out_follow_nxt  = out_follow_r;
    out_last_nxt    = out_last_r;
    div_start       = 1'b0;
    mul_start       = 1'b0;
    in_tready       = (state_r == acenc_pkg::S_IDLE);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      acenc_pkg::S_IDLE: begin
        if (in_tvalid) begin
          lc_nxt = in_lc;
          hc_nxt = in_hc;
          if (in_tuser[0] == acenc_pkg::OP_FLUSH) begin
            state_nxt = acenc_pkg::S_FLUSH;
          end else if (item_ok) begin
            div_start = 1'b1;
            state_nxt = acenc_pkg::S_DIV;
          end
        end
      end
      acenc_pkg::S_DIV: begin
        if (div_done) begin
          // an interval narrower than scale drops the item
          if (quot == '0) begin
            state_nxt = acenc_pkg::S_IDLE;
          end else begin
            mul_start = 1'b1;
            state_nxt = acenc_pkg::S_MUL;
          end
        end
      end
      acenc_pkg::S_MUL: begin
        if (mul_done) begin
          hi_nxt    = sum_h[VB-1:0];
          lo_nxt    = sum_l[VB-1:0];
          n_nxt     = '0;
          state_nxt = acenc_pkg::S_RENORM;
        end
      end
      acenc_pkg::S_RENORM: begin
        if (top_eq) begin
          if (n_r == RW'(acenc_pkg::MAX_RESULTS)) begin
            state_nxt = acenc_pkg::S_DONE;
          end else if (!hold_v_r || out_free) begin
            // push the held group as not-last; the new one waits to learn if it is last
            if (hold_v_r) begin
              out_valid_nxt  = 1'b1;
              out_lead_nxt   = hold_bit_r;
              out_follow_nxt = hold_follow_r;
              out_last_nxt   = 1'b0;
            end
            hold_v_nxt      = 1'b1;
            hold_bit_nxt    = hi_r[VB-1];
            hold_follow_nxt = pend_r;
            pend_nxt        = '0;
            n_nxt           = n_r + RW'(1);
            lo_nxt          = {lo_r[VB-2:0], 1'b0};
            hi_nxt          = {hi_r[VB-2:0], 1'b1};
          end
        end else if (straddle) begin
          if (pend_r != acenc_pkg::PEND_MAX) begin
            pend_nxt = pend_r + FW'(1);
          end
          lo_nxt = {lo_tog[VB-2:0], 1'b0};
          hi_nxt = {hi_tog[VB-2:0], 1'b1};
        end else begin
          state_nxt = acenc_pkg::S_DONE;
        end
      end
      acenc_pkg::S_DONE: begin
        if (!hold_v_r) begin
          state_nxt = acenc_pkg::S_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_lead_nxt   = hold_bit_r;
          out_follow_nxt = hold_follow_r;
          out_last_nxt   = 1'b1;
          hold_v_nxt     = 1'b0;
          state_nxt      = acenc_pkg::S_IDLE;
        end
      end
      acenc_pkg::S_FLUSH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_lead_nxt   = lo_r[VB-2];
          out_follow_nxt = (pend_r == acenc_pkg::PEND_MAX) ? acenc_pkg::PEND_MAX
                                                           : pend_r + FW'(1);
          out_last_nxt   = 1'b1;
          lo_nxt         = '0;
          hi_nxt         = '1;
          pend_nxt       = '0;
          state_nxt      = acenc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = acenc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    lc_r          <= lc_nxt;
    hc_r          <= hc_nxt;
    hold_bit_r    <= hold_bit_nxt;
    hold_follow_r <= hold_follow_nxt;
    out_lead_r    <= out_lead_nxt;
    out_follow_r  <= out_follow_nxt;
    out_last_r    <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= acenc_pkg::S_IDLE;
      lo_r        <= '0;
      hi_r        <= '1;
      pend_r      <= '0;
      n_r         <= '0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      pend_r      <= pend_nxt;
      n_r         <= n_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_idle_no_held_group: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !hold_v_r)
    else $error("input taken while a group is still held");

  a_idle_interval_normalized: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == acenc_pkg::S_IDLE) |-> (hi_r[VB-1] != lo_r[VB-1]))
    else $error("interval left unnormalized at idle");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == acenc_pkg::S_DIV))
    else $error("divider finished outside the divide phase");

  a_group_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= RW'(acenc_pkg::MAX_RESULTS))
    else $error("group count beyond limit");

endmodule

@@ tb/sv/arithmetic_encoder_bitwise_test.sv @@
// Self-checking testbench for the bitwise arithmetic encoder stream block.
`timescale 1ns / 1ps

module arithmetic_encoder_bitwise_test;
  import acenc_pkg::*;

  localparam int CB        = CODE_BITS_DEF;
  localparam int VW        = CB - 1;
  localparam int TOP_I     = VW - 1;
  localparam int NEXT_I    = VW - 2;
  localparam int STALL_MAX = 4000;
  localparam int DRAIN_CYC = 150;
  localparam int N_RANDOM  = 100;

  typedef struct {
    bit            lead;
    bit [FOLLOW_W-1:0] follow;
    bit            last;
  } code_group_t;

  class bitstream_tracker;
    bit [VW-1:0]       lo;
    bit [VW-1:0]       hi;
    bit [FOLLOW_W-1:0] owed;
    code_group_t       due_groups[$];
    int                errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      lo   = '0;
      hi   = '1;
      owed = '0;
    endfunction

    function int outstanding();
      return due_groups.size();
    endfunction

    function void push_group(bit lead, bit [FOLLOW_W-1:0] follow, bit last);
      code_group_t g;
      g.lead   = lead;
      g.follow = follow;
      g.last   = last;
      due_groups.push_back(g);
    endfunction

    // Note an accepted transfer and queue the groups it must produce.
    function void take_symbol(op_t op, bit [CNT_W-1:0] lc, bit [CNT_W-1:0] hc,
                              bit [CNT_W-1:0] sc);
      bit [CB:0]   span;
      bit [63:0]   r;
      bit [63:0]   base;
      bit [63:0]   nh;
      bit [63:0]   nl;
      bit [31:0]   sc_wide;
      int          n;
      if (op == OP_FLUSH) begin
        push_group(lo[NEXT_I], (owed == PEND_MAX) ? PEND_MAX : owed + 1, 1'b1);
        restart();
        return;
      end
      sc_wide = {16'b0, sc};
      if (sc == 0 || (sc_wide >> COUNT_BITS_DEF) != 0 || hc > sc || lc >= hc)
        return;
      span = {2'b0, VW'(hi - lo)} + 1;
      r    = 64'(span) / 64'(sc);
      if (r == 0)
        return;
      base = 64'(lo);
      nh   = base + r * 64'(hc) - 1;
      nl   = base + r * 64'(lc);
      hi   = nh[VW-1:0];
      lo   = nl[VW-1:0];
      n    = 0;
      while (1) begin
        if (hi[TOP_I] == lo[TOP_I]) begin
          if (n >= MAX_RESULTS)
            break;
          push_group(hi[TOP_I], owed, 1'b0);
          owed = '0;
          n++;
        end else if (lo[NEXT_I] && !hi[NEXT_I]) begin
          if (owed != PEND_MAX)
            owed++;
          lo[NEXT_I] = ~lo[NEXT_I];
          hi[NEXT_I] = ~hi[NEXT_I];
        end else begin
          break;
        end
        lo = lo << 1;
        hi = (hi << 1) | 1;
      end
      if (n > 0)
        due_groups[due_groups.size() - 1].last = 1'b1;
    endfunction

    function void match_group(bit lead, bit [FOLLOW_W-1:0] follow, bit last);
      code_group_t g;
      if (due_groups.size() == 0) begin
        $error("unexpected group: lead_bit %0d follow_count %0d last %0d",
               lead, follow, last);
        errors++;
        return;
      end
      g = due_groups.pop_front();
      if (g.lead != lead) begin
        $error("lead_bit: expected %0d, actual %0d", g.lead, lead);
        errors++;
      end
      if (g.follow != follow) begin
        $error("follow_count: expected %0d, actual %0d", g.follow, follow);
        errors++;
      end
      if (g.last != last) begin
        $error("last: expected %0d, actual %0d", g.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [0:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  bitstream_tracker tracker;
  bit               no_idle;
  int               quiet_cycles;

  arithmetic_encoder_bitwise uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Receiver side: stall now and then, except in the steady stretch.
  always @(negedge clk) begin
    if (!rst_n || no_idle)
      out_tready <= 1'b1;
    else
      out_tready <= ($urandom_range(99) >= 8);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.match_group(out_tdata[0], out_tdata[32:1], out_tlast);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a falling edge; returns at a falling edge after the transfer.
  task automatic send_symbol(op_t op, bit [CNT_W-1:0] lc, bit [CNT_W-1:0] hc,
                             bit [CNT_W-1:0] sc);
    while (!no_idle && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {sc, hc, lc};
    do @(posedge clk); while (!in_tready);
    tracker.take_symbol(op, lc, hc, sc);
    @(negedge clk);
  endtask

  task automatic send_random();
    int          pick;
    int          sc;
    int          lc;
    int          hc;
    pick = $urandom_range(99);
    if (pick < 6) begin
      send_symbol(OP_FLUSH, CNT_W'($urandom), CNT_W'($urandom), CNT_W'($urandom));
    end else if (pick < 14) begin
      // mostly malformed, fields fully random
      send_symbol(OP_ENCODE, CNT_W'($urandom), CNT_W'($urandom), CNT_W'($urandom));
    end else begin
      if (pick < 50)
        sc = $urandom_range(16, 2);
      else
        sc = $urandom_range(65535, 2);
      lc = $urandom_range(sc - 1, 0);
      // favor narrow symbols so renormalization runs deep
      if ($urandom_range(1))
        hc = lc + 1;
      else
        hc = $urandom_range(sc, lc + 1);
      send_symbol(OP_ENCODE, CNT_W'(lc), CNT_W'(hc), CNT_W'(sc));
    end
  endtask

  initial begin
    tracker    = new();
    no_idle    = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = OP_ENCODE;
    out_tready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, both operations, malformed items and underflow runs
    send_symbol(OP_FLUSH,  16'd0,     16'd0,     16'd0);
    send_symbol(OP_ENCODE, 16'd0,     16'd1,     16'd65535);
    send_symbol(OP_ENCODE, 16'd65534, 16'd65535, 16'd65535);
    send_symbol(OP_ENCODE, 16'd0,     16'd65535, 16'd65535);
    send_symbol(OP_ENCODE, 16'd0,     16'd1,     16'd1);
    send_symbol(OP_ENCODE, 16'd0,     16'd0,     16'd0);
    send_symbol(OP_ENCODE, 16'd0,     16'd65535, 16'd100);
    send_symbol(OP_ENCODE, 16'd65535, 16'd65535, 16'd65535);
    send_symbol(OP_ENCODE, 16'd5,     16'd3,     16'd10);
    send_symbol(OP_ENCODE, 16'd1,     16'd3,     16'd4);
    send_symbol(OP_ENCODE, 16'd1,     16'd3,     16'd4);
    send_symbol(OP_ENCODE, 16'd1,     16'd3,     16'd4);
    send_symbol(OP_FLUSH,  16'hFFFF,  16'hFFFF,  16'hFFFF);
    send_symbol(OP_ENCODE, 16'd2,     16'd3,     16'd4);
    send_symbol(OP_ENCODE, 16'd0,     16'd1,     16'd2);
    send_symbol(OP_ENCODE, 16'd1,     16'd2,     16'd3);
    send_symbol(OP_FLUSH,  16'd0,     16'd0,     16'd0);

    for (int i = 0; i < N_RANDOM; i++) begin
      no_idle = (i >= 30 && i < 70);
      if (i == 80) begin
        // hold the sender until the block has drained
        in_tvalid <= 1'b0;
        while (tracker.outstanding() != 0) @(negedge clk);
        @(negedge clk);
      end
      send_random();
    end
    send_symbol(OP_FLUSH, 16'd0, 16'd0, 16'd0);
    in_tvalid <= 1'b0;
    no_idle = 1'b0;

    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (tracker.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
